// ===== hw/rtl/mst_pkg.sv =====
// Package for the multi-slot one-shot timer.
// Holds the beat types, the command, kind and status codes, and the default sizes.
// It has no dependencies.
package mst_pkg;

  localparam int unsigned SLOT_COUNT  = 8;
  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned ENTRY_W     = 2 * TIME_W;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_EXPIRED = 2'd1;
  localparam logic [1:0] KIND_IDLE    = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_BUSY    = 2'd2;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        timer_id;
    logic [TIME_W-1:0] delay_ms;
    logic              force_req;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] slot;
    logic [1:0] status;
    logic       last;
  } out_beat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_e;

endpackage

// ===== hw/rtl/multi_slot_oneshot_timer.sv =====
// Top level of the multi-slot one-shot timer: sequencer, slot RAM and shared compare unit.
// A set or cancel beat goes through S_EXEC, which acknowledges it once the output is free, and
// the sequencer then returns to idle for the next beat; cmd 3 returns to idle with no result.
// A tick scans up to SlotCount slots, one per cycle while no output stall holds the scan, and
// S_FIN then sends its last result before the sequencer returns to idle for the next beat.
// Reset clears the time counter, armed flags and control state; RAM contents stay undefined.
module multi_slot_oneshot_timer import mst_pkg::*; #(
  parameter int unsigned SlotCount = SLOT_COUNT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  localparam int unsigned IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam int unsigned CntW = $clog2(MAX_RESULTS + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);

  state_e state_q, state_d;

  logic [TIME_W-1:0]    now_q, now_d;
  logic [SlotCount-1:0] armed_q, armed_d;
  logic [IdxW-1:0]      idx_q, idx_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic                 pend_v_q, pend_v_d;
  logic [IdxW-1:0]      pend_q, pend_d;
  in_beat_t             cmd_q, cmd_d;
  logic                 out_valid_q, out_valid_d;
  out_beat_t            out_q, out_d;

  logic                 ram_we;
  logic [ENTRY_W-1:0]   ram_wdata;
  logic [ENTRY_W-1:0]   ram_rdata;
  logic                 due;

  logic                 accept;
  logic                 out_free;
  logic                 hit;
  logic                 stall;
  logic                 scan_done;
  logic                 id_ok;
  logic [IdxW-1:0]      cmd_idx;
  logic                 do_arm;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign hit      = armed_q[idx_q] && due;
  assign stall    = hit && pend_v_q && !out_free;
  assign scan_done = !stall && ((idx_q == LastIdx) ||
                                (hit && (cnt_q == CntW'(MAX_RESULTS - 1))));
  assign id_ok    = cmd_q.timer_id < 8'(SlotCount);
  assign cmd_idx  = cmd_q.timer_id[IdxW-1:0];
  assign do_arm   = id_ok && (!armed_q[cmd_idx] || cmd_q.force_req);
  assign ram_wdata = {now_q, cmd_q.delay_ms};

  mst_ram #(
    .Width (ENTRY_W),
    .Depth (SlotCount)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_idx),
    .wdata_i (ram_wdata),
    .raddr_i (idx_d),
    .rdata_o (ram_rdata)
  );

  mst_due u_due (
    .now_i   (now_q),
    .start_i (ram_rdata[ENTRY_W-1:TIME_W]),
    .delay_i (ram_rdata[TIME_W-1:0]),
    .due_o   (due)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.cmd == CMD_TICK) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q.cmd != CMD_SET && cmd_q.cmd != CMD_CANCEL) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    now_d      = now_q;
    armed_d    = armed_q;
    idx_d      = idx_q;
    cnt_d      = cnt_q;
    pend_v_d   = pend_v_q;
    pend_d     = pend_q;
    cmd_d      = cmd_q;
    ram_we     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d      = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d    = in_data_i;
          idx_d    = '0;
          cnt_d    = '0;
          pend_v_d = 1'b0;
          if (in_data_i.cmd == CMD_TICK) begin
            now_d = now_q + 1'b1;
          end
        end
      end
      S_EXEC: begin
        if ((cmd_q.cmd == CMD_SET || cmd_q.cmd == CMD_CANCEL) && out_free) begin
          out_valid_d   = 1'b1;
          out_d.kind    = KIND_ACK;
          out_d.slot    = cmd_q.timer_id;
          out_d.last    = 1'b1;
          out_d.status  = STAT_DONE;
          if (!id_ok) begin
            out_d.status = STAT_INVALID;
          end else if (cmd_q.cmd == CMD_CANCEL) begin
            armed_d[cmd_idx] = 1'b0;
          end else if (do_arm) begin
            ram_we           = 1'b1;
            armed_d[cmd_idx] = 1'b1;
          end else begin
            out_d.status = STAT_BUSY;
          end
        end
      end
      S_SCAN: begin
        if (!stall) begin
          if (hit) begin
            armed_d[idx_q] = 1'b0;
            cnt_d          = cnt_q + 1'b1;
            pend_v_d       = 1'b1;
            pend_d         = idx_q;
            if (pend_v_q) begin
              out_valid_d  = 1'b1;
              out_d.kind   = KIND_EXPIRED;
              out_d.slot   = 8'(pend_q);
              out_d.status = STAT_DONE;
              out_d.last   = 1'b0;
            end
          end
          if (idx_q != LastIdx) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d.status = STAT_DONE;
          out_d.last   = 1'b1;
          if (pend_v_q) begin
            out_d.kind = KIND_EXPIRED;
            out_d.slot = 8'(pend_q);
          end else begin
            out_d.kind = KIND_IDLE;
            out_d.slot = '0;
          end
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      armed_q     <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      armed_q     <= armed_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    cmd_q  <= cmd_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/mst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stores the start time and delay of every timer slot. No dependencies.
module mst_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/mst_due.sv =====
// Shared expiry compare unit of the multi-slot one-shot timer.
// Uses mst_pkg for the time width.
module mst_due import mst_pkg::*; (
  input  logic [TIME_W-1:0] now_i,
  input  logic [TIME_W-1:0] start_i,
  input  logic [TIME_W-1:0] delay_i,
  output logic              due_o
);

  logic [TIME_W-1:0] elapsed;

  assign elapsed = now_i - start_i;
  assign due_o   = elapsed > delay_i;

endmodule
